/* rtl/mks_pkg.sv */
// ============================================================================
// mks_pkg
// Shared types, keyword table and sizes for the macro keyword scanner.
// ============================================================================
`default_nettype none

package mks_pkg;

   // keyword set and window sizes
   localparam int NUM_KW     = 22;
   localparam int WIN_DEPTH  = 13;
   localparam int KW_MAX_LEN = WIN_DEPTH + 1;
   localparam int KW_BITS    = 8 * KW_MAX_LEN;
   localparam int KW_ID_W    = $clog2(NUM_KW);
   localparam int WIN_CNT_W  = $clog2(WIN_DEPTH + 1);
   localparam int LEN_W      = $clog2(KW_MAX_LEN + 1);

   // flag queue between scan and report
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef logic [7:0]           byte_type;
   typedef logic [NUM_KW-1:0]    kw_vec_type;
   typedef logic [KW_ID_W-1:0]   kw_id_type;
   typedef logic [3:0]           sev_type;
   typedef logic [LEN_W-1:0]     len_type;
   typedef logic [WIN_CNT_W-1:0] win_cnt_type;
   typedef logic [KW_BITS-1:0]   kw_text_type;

   // keyword text, right aligned: the keyword's last char sits in bits [7:0]
   localparam kw_text_type KW_TEXT [NUM_KW] = '{
      "AutoOpen",       {"Workbook", "_Open"},
      {"Document", "_Open"},                  "DocumentOpen",
      "AutoExec",       "AutoExit",
      {"Auto", "_Close"},                     "AutoClose",
      "DocumentChange", "AutoNew",
      {"Document", "_New"},                   "NewDocument",
      "CreateObject",   "allocateMemory", "copyMemory",    "shellExecute",
      "Environ",        "Open",           "Write",         "Put",
      "Binary",         "Shell"
   };

   localparam len_type KW_LEN [NUM_KW] = '{
      len_type'(8),  len_type'(13), len_type'(13), len_type'(12),
      len_type'(8),  len_type'(8),  len_type'(10), len_type'(9),
      len_type'(14), len_type'(7),  len_type'(12), len_type'(11),
      len_type'(12), len_type'(14), len_type'(10), len_type'(12),
      len_type'(7),  len_type'(4),  len_type'(5),  len_type'(3),
      len_type'(6),  len_type'(5)
   };

   localparam sev_type KW_SEV [NUM_KW] = '{
      sev_type'(7),  sev_type'(7),  sev_type'(7),  sev_type'(7),
      sev_type'(10), sev_type'(9),  sev_type'(7),  sev_type'(7),
      sev_type'(9),  sev_type'(10), sev_type'(9),  sev_type'(8),
      sev_type'(8),  sev_type'(8),  sev_type'(8),  sev_type'(8),
      sev_type'(8),  sev_type'(8),  sev_type'(8),  sev_type'(8),
      sev_type'(8),  sev_type'(8)
   };

endpackage

`default_nettype wire

/* rtl/mks_scan.sv */
// ============================================================================
// mks_scan
// Front end: byte window, parallel keyword comparators and found flags.
// On a script's final byte the final flag word goes to the queue.
// ============================================================================
`default_nettype none

module mks_scan import mks_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire byte_type   req_text_byte,
   input  wire logic       req_end_of_script,
   output      logic       push_valid,
   input  wire logic       push_ready,
   output      kw_vec_type push_flags
);

   byte_type    win_ff [WIN_DEPTH];
   win_cnt_type win_cnt_ff, win_cnt_in;
   kw_vec_type  found_ff, found_in;
   kw_vec_type  match;
   byte_type    taps [KW_MAX_LEN];
   logic        accept;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   // taps: current byte, then the window, newest first
   always_comb begin
      taps[0] = req_text_byte;
      for (int i = 1; i < KW_MAX_LEN; i++) begin
         taps[i] = win_ff[i-1];
      end
   end

   // one comparator per keyword, each over its own length
   always_comb begin
      for (int k = 0; k < NUM_KW; k++) begin
         match[k] = ((KW_LEN[k] - len_type'(1)) <= len_type'(win_cnt_ff));
         for (int i = 0; i < KW_MAX_LEN; i++) begin
            if (len_type'(i) < KW_LEN[k]) begin
               if (taps[i] != KW_TEXT[k][8*i +: 8]) begin
                  match[k] = 1'b0;
               end
            end
         end
      end
   end

   // flags and window fill
   always_comb begin
      found_in   = found_ff;
      win_cnt_in = win_cnt_ff;
      if (accept) begin
         if (req_end_of_script) begin
            found_in   = '0;
            win_cnt_in = '0;
         end else begin
            found_in = found_ff | match;
            if (win_cnt_ff != win_cnt_type'(WIN_DEPTH)) begin
               win_cnt_in = win_cnt_ff + win_cnt_type'(1);
            end
         end
      end
   end

   assign push_valid = accept && req_end_of_script;
   assign push_flags = found_ff | match;

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff   <= '0;
         win_cnt_ff <= '0;
      end else begin
         found_ff   <= found_in;
         win_cnt_ff <= win_cnt_in;
      end
   end

   // byte window shift, contents gated by the fill count
   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff[0] <= req_text_byte;
         for (int i = 1; i < WIN_DEPTH; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/mks_queue.sv */
// ============================================================================
// mks_queue
// Small FIFO of per-script flag words between the scan and report sides.
// ============================================================================
`default_nettype none

module mks_queue import mks_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       wr_valid,
   output      logic       wr_ready,
   input  wire kw_vec_type wr_flags,
   output      logic       rd_valid,
   input  wire logic       rd_ready,
   output      kw_vec_type rd_flags
);

   kw_vec_type         mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] cnt_ff, cnt_in;
   logic               do_wr, do_rd;

   assign wr_ready = (cnt_ff != Q_CNT_W'(Q_DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_flags = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + Q_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_flags;
      end
   end

endmodule

`default_nettype wire

/* rtl/mks_report.sv */
// ============================================================================
// mks_report
// Back end: walks one flag word lowest id first and emits one result word
// per set flag, or one no-hit word, through an output register.
// ============================================================================
`default_nettype none

module mks_report import mks_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       pop_valid,
   output      logic       pop_ready,
   input  wire kw_vec_type pop_flags,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic       rsp_hit,
   output      kw_id_type  rsp_keyword_id,
   output      sev_type    rsp_severity,
   output      logic       rsp_last_of_run
);

   logic       busy_ff, busy_in;
   kw_vec_type flags_ff, flags_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       hit_ff, hit_in;
   kw_id_type  id_ff, id_in;
   sev_type    sev_ff, sev_in;
   logic       last_ff, last_in;
   kw_id_type  sel;
   kw_vec_type remaining;
   logic       step;

   assign pop_ready = !busy_ff;
   assign step      = busy_ff && (!rsp_valid_ff || rsp_ready);

   // lowest set flag
   always_comb begin
      sel = '0;
      for (int i = NUM_KW - 1; i >= 0; i--) begin
         if (flags_ff[i]) begin
            sel = kw_id_type'(i);
         end
      end
      remaining = flags_ff & ~(kw_vec_type'(1) << sel);
   end

   // next result word and walk state
   always_comb begin
      busy_in      = busy_ff;
      flags_in     = flags_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      hit_in       = hit_ff;
      id_in        = id_ff;
      sev_in       = sev_ff;
      last_in      = last_ff;
      if (!busy_ff) begin
         if (pop_valid) begin
            busy_in  = 1'b1;
            flags_in = pop_flags;
         end
      end else if (step) begin
         rsp_valid_in = 1'b1;
         if (flags_ff == '0) begin
            // no keyword in this script
            hit_in  = 1'b0;
            id_in   = '0;
            sev_in  = '0;
            last_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            hit_in   = 1'b1;
            id_in    = sel;
            sev_in   = KW_SEV[sel];
            last_in  = (remaining == '0);
            busy_in  = (remaining != '0);
            flags_in = remaining;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff <= flags_in;
      hit_ff   <= hit_in;
      id_ff    <= id_in;
      sev_ff   <= sev_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_keyword_id  = id_ff;
   assign rsp_severity    = sev_ff;
   assign rsp_last_of_run = last_ff;

endmodule

`default_nettype wire

/* rtl/macro_keyword_scanner.sv */
// ============================================================================
// macro_keyword_scanner
// Scans script bytes for 22 fixed keywords and reports the ones found.
// ============================================================================
// Usage:
//   req_ channel: one script byte per word, req_end_of_script on the last
//   byte. A byte is taken every cycle while req_ready is high; the scan side
//   compares the byte and a 13-byte window against all keywords in parallel.
//   rsp_ channel: at the end of each script, one word per keyword found, in
//   id order, or a single no-hit word; rsp_last_of_run marks the final one.
//   With the report side idle, the final flag word is written to the queue,
//   then loaded into the report flag register, then into the output
//   register as the first result word. Results leave one per cycle while
//   rsp_ready is high, pausing between scripts while the next flag word loads.
//   Throughput: 1 byte per cycle on the input while the queue has room; the
//   report side walks one flag per cycle. A 2-entry flag queue sits between
//   scan and report, so req_ready drops only when two finished scripts wait
//   behind the one being reported, as under a stalled receiver or a run of
//   very short scripts; when rsp_ready is low the output register holds.
//   Reset (synchronous, active high) empties the window, flags and queue
//   and drops rsp_valid.
// ============================================================================
`default_nettype none

module macro_keyword_scanner import mks_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output      logic      req_ready,
   input  wire byte_type  req_text_byte,
   input  wire logic      req_end_of_script,
   output      logic      rsp_valid,
   input  wire logic      rsp_ready,
   output      logic      rsp_hit,
   output      kw_id_type rsp_keyword_id,
   output      sev_type   rsp_severity,
   output      logic      rsp_last_of_run
);

   logic       push_valid, push_ready;
   kw_vec_type push_flags;
   logic       pop_valid, pop_ready;
   kw_vec_type pop_flags;

   mks_scan u_scan (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_text_byte     (req_text_byte),
      .req_end_of_script (req_end_of_script),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_flags        (push_flags)
   );

   mks_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_flags (push_flags),
      .rd_valid (pop_valid),
      .rd_ready (pop_ready),
      .rd_flags (pop_flags)
   );

   mks_report u_report (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_flags       (pop_flags),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_keyword_id  (rsp_keyword_id),
      .rsp_severity    (rsp_severity),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // a finished script is in the queue right after its final byte
   a_end_queued: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_end_of_script |=> pop_valid)
      else $error("final byte did not reach the flag queue");

   // a no-hit word is always the last and carries zero id and severity
   a_nohit_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_last_of_run && rsp_keyword_id == '0
                                && rsp_severity == '0)
      else $error("malformed no-hit result");

   // a hit word carries a listed id and its table severity
   a_hit_sev: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_keyword_id < kw_id_type'(NUM_KW)
                               && rsp_severity == KW_SEV[rsp_keyword_id])
      else $error("hit result with bad id or severity");

   // output register is empty after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

`default_nettype wire

/* tb/macro_keyword_scanner_tb.sv */
// ============================================================================
// macro_keyword_scanner_tb
// Self-checking bench for the script keyword scanner. Scripts are sent one
// byte per word; a tracker keeps its own window and found flags, predicts
// the report words of each script and checks every word that leaves the
// block, field by field, in order. Random bursts on the request side and
// stall patterns on the response side, including one long hold-off that
// backs the block up into its input.
// ============================================================================
`default_nettype none

module macro_keyword_scanner_tb import mks_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int KW_COUNT    = 22;
   localparam int HIST_DEPTH  = 13;
   localparam int RAND_BYTES  = 200;
   localparam int HOLD_CYCLES = 100;
   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 20;

   // one report word as the block presents it
   typedef struct packed {
      logic      hit;
      kw_id_type keyword_id;
      sev_type   severity;
      logic      last_of_run;
   } scan_report_type;

   // response stall patterns
   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_THIRD, RX_MOSTLY} rx_mode_type;

   // -------------------------------------------------------------------------
   // Keyword tracker: own window and flags, queue of predicted report words
   // -------------------------------------------------------------------------
   class keyword_tracker_type;
      string           kw_text [KW_COUNT];
      int              kw_sev [KW_COUNT];
      byte_type        window [HIST_DEPTH];
      int              win_fill;
      kw_vec_type      found;
      kw_vec_type      seen_kw;
      scan_report_type pending_reports [$];
      int              errors;
      int              scripts_seen;
      int              bytes_seen;
      int              words_checked;

      function new();
         kw_text = '{"AutoOpen",
                     $sformatf("%s_%s", "Workbook", "Open"),
                     $sformatf("%s_%s", "Document", "Open"),
                     "DocumentOpen", "AutoExec", "AutoExit",
                     $sformatf("%s_%s", "Auto", "Close"),
                     "AutoClose", "DocumentChange", "AutoNew",
                     $sformatf("%s_%s", "Document", "New"),
                     "NewDocument", "CreateObject", "allocateMemory",
                     "copyMemory", "shellExecute", "Environ", "Open",
                     "Write", "Put", "Binary", "Shell"};
         kw_sev  = '{7, 7, 7, 7, 10, 9, 7, 7, 9, 10, 9, 8,
                     8, 8, 8, 8, 8, 8, 8, 8, 8, 8};
         clear();
         seen_kw       = '0;
         errors        = 0;
         scripts_seen  = 0;
         bytes_seen    = 0;
         words_checked = 0;
      endfunction

      function void clear();
         foreach (window[i]) window[i] = '0;
         win_fill = 0;
         found    = '0;
      endfunction

      function int pending();
         return pending_reports.size();
      endfunction

      // does keyword k end with byte cur, given the bytes held in the window
      function bit ends_here(int k, byte_type cur);
         int n;
         n = kw_text[k].len();
         if (byte_type'(kw_text[k][n-1]) != cur) return 1'b0;
         if (n - 1 > win_fill) return 1'b0;
         for (int i = 1; i < n; i++)
            if (byte_type'(kw_text[k][n-1-i]) != window[i-1]) return 1'b0;
         return 1'b1;
      endfunction

      // accepted request word: scan it, and on the final byte queue the report
      function void take_byte(byte_type b, logic eos);
         scan_report_type r;
         int last_k;
         bytes_seen++;
         for (int k = 0; k < KW_COUNT; k++)
            if (ends_here(k, b)) found[k] = 1'b1;
         for (int i = HIST_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
         window[0] = b;
         if (win_fill < HIST_DEPTH) win_fill++;
         if (!eos) return;

         scripts_seen++;
         last_k = -1;
         for (int k = 0; k < KW_COUNT; k++)
            if (found[k]) last_k = k;
         if (last_k < 0) begin
            r = '0;
            r.last_of_run = 1'b1;
            pending_reports.insert(pending_reports.size(), r);
         end else begin
            for (int k = 0; k <= last_k; k++) begin
               if (found[k]) begin
                  r.hit         = 1'b1;
                  r.keyword_id  = kw_id_type'(k);
                  r.severity    = sev_type'(kw_sev[k]);
                  r.last_of_run = (k == last_k);
                  pending_reports.insert(pending_reports.size(), r);
                  seen_kw[k] = 1'b1;
               end
            end
         end
         clear();
      endfunction

      function void field_error(string field, int want, int got);
         errors++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      endfunction

      // accepted response word: compare with the oldest prediction
      function void match_report(logic hit, kw_id_type id, sev_type sev, logic last);
         scan_report_type want;
         words_checked++;
         if (pending_reports.size() == 0) begin
            errors++;
            $display("%0t: unexpected report word: expected none, %s %0d %0d %0d %0d",
                     $time, "actual hit/id/sev/last", hit, id, sev, last);
            return;
         end
         want = pending_reports.pop_front();
         if (hit !== want.hit)                field_error("hit", want.hit, hit);
         if (id !== want.keyword_id)          field_error("keyword_id", want.keyword_id, id);
         if (sev !== want.severity)           field_error("severity", want.severity, sev);
         if (last !== want.last_of_run)       field_error("last_of_run", want.last_of_run, last);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals
   // -------------------------------------------------------------------------
   logic      clock;
   logic      reset             = 1'b1;
   logic      req_valid         = 1'b0;
   logic      req_ready;
   byte_type  req_text_byte     = '0;
   logic      req_end_of_script = 1'b0;
   logic      rsp_valid;
   logic      rsp_ready         = 1'b0;
   logic      rsp_hit;
   kw_id_type rsp_keyword_id;
   sev_type   rsp_severity;
   logic      rsp_last_of_run;

   keyword_tracker_type sb;
   byte_type            script_q [$];
   int                  burst_left = 4;
   int                  byte_count = 0;
   int                  kw_rot     = 0;
   int                  hold_reqs  = 0;
   int                  hold_seen  = 0;
   int                  hold_left  = 0;
   int                  pat_cnt    = 0;
   rx_mode_type         rx_mode    = RX_OPEN;
   int                  quiet      = 0;

   macro_keyword_scanner DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_text_byte     (req_text_byte),
      .req_end_of_script (req_end_of_script),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_keyword_id    (rsp_keyword_id),
      .rsp_severity      (rsp_severity),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Monitor: every accepted word on either channel goes to the tracker
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.take_byte(req_text_byte, req_end_of_script);
         if (rsp_valid && rsp_ready)
            sb.match_report(rsp_hit, rsp_keyword_id, rsp_severity, rsp_last_of_run);
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: stall pattern redrawn at random by a pattern counter; long hold-off on request
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_reqs != hold_seen) begin
         hold_seen <= hold_reqs;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         pat_cnt <= pat_cnt + 1;
         if (pat_cnt % 64 == 63) rx_mode <= rx_mode_type'($urandom_range(0, 3));
         case (rx_mode)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            RX_THIRD:  rsp_ready <= (pat_cnt % 3 == 0);
            RX_MOSTLY: rsp_ready <= ($urandom_range(0, 9) != 0);
            default:   rsp_ready <= 1'b1;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: too long with nothing accepted on either side
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d report words outstanding",
                  $time, QUIET_LIMIT, sb.pending());
         $display("FAIL macro_keyword_scanner");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   task automatic send_word(input byte_type b, input logic eos);
      req_valid         <= 1'b1;
      req_text_byte     <= b;
      req_end_of_script <= eos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic idle_gap(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // stop sending until every predicted report word has come out
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // send the queued script, final mark on its last byte
   task automatic play_script();
      for (int i = 0; i < script_q.size(); i++) begin
         send_word(script_q[i], i == script_q.size() - 1);
         byte_count++;
         if (burst_left > 0) burst_left--;
         if (burst_left == 0) begin
            idle_gap($urandom_range(1, 8));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
         end
      end
      script_q.delete();
   endtask

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) script_q.insert(script_q.size(), byte_type'(s[i]));
   endfunction

   // noise: half uniform bytes, half letters taken from the keywords
   function automatic void add_noise(input int n);
      int k;
      int j;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 1)) begin
            script_q.insert(script_q.size(), byte_type'($urandom_range(0, 255)));
         end else begin
            k = $urandom_range(0, KW_COUNT - 1);
            j = $urandom_range(0, sb.kw_text[k].len() - 1);
            script_q.insert(script_q.size(), byte_type'(sb.kw_text[k][j]));
         end
      end
   endfunction

   // mostly walk the list so every keyword shows up, sometimes pick at random
   function automatic int next_keyword();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, KW_COUNT - 1);
      kw_rot = (kw_rot + 1) % KW_COUNT;
      return kw_rot;
   endfunction

   task automatic random_script();
      int    kind;
      string s;
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
         // well formed: keywords with noise around them
         add_noise($urandom_range(0, 3));
         repeat ($urandom_range(1, 3)) begin
            add_text(sb.kw_text[next_keyword()]);
            add_noise($urandom_range(0, 3));
         end
      end else if (kind == 7) begin
         // keyword cut short by one letter
         s = sb.kw_text[next_keyword()];
         add_noise($urandom_range(0, 2));
         add_text(s.substr(0, s.len() - 2));
         add_noise($urandom_range(0, 2));
      end else if (kind == 8) begin
         add_noise($urandom_range(1, 10));
      end else begin
         add_noise(1);
      end
      play_script();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: lone keyword, single-byte scripts at both byte extremes,
      // keyword split over two scripts, overlapping keywords
      add_text("Put");       play_script();
      script_q.insert(script_q.size(), 8'h00); play_script();
      script_q.insert(script_q.size(), 8'hFF); play_script();
      add_text("Pu");        play_script();
      add_text("t");         play_script();
      add_text("AutoOpen");  play_script();
      add_text("Shell");     play_script();
      drain();

      // receiver holds off while short scripts keep coming, input backs up
      hold_reqs  <= hold_reqs + 1;
      burst_left = 1000;
      repeat (6) begin
         add_noise($urandom_range(0, 1));
         add_text(sb.kw_text[next_keyword() % 4 + 17]);
         play_script();
      end
      burst_left = 1;
      drain();

      // random scripts until the whole run reaches its byte count
      while (byte_count < RAND_BYTES) begin
         random_script();
         if ($urandom_range(0, 11) == 0) drain();
      end

      // wind down
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (sb.pending() != 0)
         $display("%0t: %0d predicted report words never arrived", $time, sb.pending());
      $display("Run covered %0d scripts, %0d bytes, %0d report words checked.",
               sb.scripts_seen, sb.bytes_seen, sb.words_checked);
      $display("Keywords reported: %0d of %0d, mismatches: %0d.",
               $countones(sb.seen_kw), KW_COUNT, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS macro_keyword_scanner");
      end else begin
         $display("FAIL macro_keyword_scanner");
      end
      $finish;
   end

endmodule

`default_nettype wire
